// ===== design/ordered_key_value_table_defines.svh =====
// assertion macros for the ordered key-value table
// each macro expects clk and arst_n in the scope of use
`ifndef ORDERED_KEY_VALUE_TABLE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define OKV_ASSERT_SAME(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("okv: same-cycle check failed");
`define OKV_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("okv: next-cycle check failed");
`else
`define OKV_ASSERT_SAME(lbl, ante, cons)
`define OKV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/okv_pkg.sv =====
package okv_pkg;

	localparam int CAPACITY    = 16;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int CMD_BITS    = 3;
	localparam int STATUS_BITS = 3;
	localparam int RANK_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

	// command codes
	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOOKUP     = 3'd0,
		CMD_INS_FRONT  = 3'd1,
		CMD_INS_BACK   = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_POP_FIRST  = 3'd4,
		CMD_POP_LAST   = 3'd5,
		CMD_MOVE_BACK  = 3'd6
	} okv_cmd_t;

	// status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 3'd0,
		ST_EXISTS  = 3'd1,
		ST_MISSING = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4
	} okv_status_t;

	// per-cell update actions
	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_INS_FRONT = 3'd1,
		ACT_INS_BACK  = 3'd2,
		ACT_DROP      = 3'd3,
		ACT_MOVE      = 3'd4
	} okv_act_t;

	// match broadcast to every cell
	typedef struct packed {
		logic                 en;
		logic                 by_rank;
		logic [KEY_BITS-1:0]  key;
		logic [RANK_BITS-1:0] rank;
	} okv_match_t;

	// data handed from cell to cell
	typedef struct packed {
		logic                  hit;
		logic                  free_seen;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [RANK_BITS-1:0]  rank;
	} okv_chain_t;

	// update broadcast to every cell
	typedef struct packed {
		logic                  en;
		okv_act_t              act;
		logic [RANK_BITS-1:0]  rank;
		logic [COUNT_BITS-1:0] count;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} okv_upd_t;

endpackage

// ===== design/okv_in_if.sv =====
interface okv_in_if import okv_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   cmd;
	logic [KEY_BITS-1:0]   req_key;
	logic [VALUE_BITS-1:0] req_value;

	modport source (output valid, output cmd, output req_key, output req_value, input ready);
	modport sink (input valid, input cmd, input req_key, input req_value, output ready);
endinterface

// ===== design/okv_out_if.sv =====
interface okv_out_if import okv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [KEY_BITS-1:0]    res_key;
	logic [VALUE_BITS-1:0]  res_value;
	logic [COUNT_BITS-1:0]  entry_count;

	modport source (output valid, output status, output res_key, output res_value,
		output entry_count, input ready);
	modport sink (input valid, input status, input res_key, input res_value,
		input entry_count, output ready);
endinterface

// ===== design/okv_cell.sv =====
module okv_cell import okv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  okv_match_t match,
	input  okv_upd_t   upd,
	input  okv_chain_t chain_in,
	output okv_chain_t chain_out,
	output logic       hit
);

	logic                  valid_q;
	logic                  hit_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic                  first_free;
	logic                  after_gap;

	assign first_free = !valid_q && !chain_in.free_seen;
	assign after_gap  = valid_q && (rank_q > upd.rank);
	assign hit        = hit_q;

	// pass the earlier hit along, or put this one on the chain
	always_comb begin
		chain_out           = chain_in;
		chain_out.free_seen = chain_in.free_seen | !valid_q;
		if (hit_q) begin
			chain_out.hit   = 1'b1;
			chain_out.key   = key_q;
			chain_out.value = value_q;
			chain_out.rank  = rank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (match.en) begin
				hit_q <= valid_q && (match.by_rank ? (rank_q == match.rank) : (key_q == match.key));
			end
			if (upd.en) begin
				case (upd.act)
					ACT_INS_FRONT, ACT_INS_BACK: begin
						if (first_free) valid_q <= 1'b1;
					end
					ACT_DROP: begin
						if (hit_q) valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			case (upd.act)
				ACT_INS_FRONT: begin
					if (first_free) begin
						key_q   <= upd.key;
						value_q <= upd.value;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				ACT_INS_BACK: begin
					if (first_free) begin
						key_q   <= upd.key;
						value_q <= upd.value;
						rank_q  <= upd.count[RANK_BITS-1:0];
					end
				end
				ACT_DROP: begin
					if (!hit_q && after_gap) rank_q <= rank_q - 1'b1;
				end
				ACT_MOVE: begin
					if (hit_q) begin
						rank_q <= RANK_BITS'(upd.count - 1'b1);
					end else if (after_gap) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/ordered_key_value_table.sv =====
// ordered key-value table: up to 16 entries with unique keys, kept in insertion order
// req channel (valid/ready): cmd, req_key, req_value; a transfer is one command
// rsp channel (valid/ready): status, res_key, res_value, entry_count, one per command
// storage is a row of identical cells, one per slot, each holding key, value,
// a valid flag and its rank in the order (0 is the front)
// a request transfer is followed by a match state and an update state:
//   match:  every cell compares its key (or its rank) with the request
//   update: the hit and the first free slot ripple down the cell row, the
//           status is formed and all cells update their ranks together
// overlap: a command is matched only after the previous command's update
// across the row, which the next match depends on
// a new request is taken in the update cycle, so the output register hides the
// handshake of the previous result
// reset: all cells empty, count zero, no result pending; no clearing pass
// receiver stall: the finished result waits in the output register; a second
// command is matched but holds in its update cycle until that result is taken
`include "ordered_key_value_table_defines.svh"

module ordered_key_value_table import okv_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	okv_in_if.sink   req,
	okv_out_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t                  state_q;

	// accepted command
	logic [CMD_BITS-1:0]     cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [COUNT_BITS-1:0]   count_q;

	// output register
	logic                    out_valid_q;
	logic [STATUS_BITS-1:0]  status_q;
	logic [KEY_BITS-1:0]     res_key_q;
	logic [VALUE_BITS-1:0]   res_value_q;
	logic [COUNT_BITS-1:0]   res_count_q;

	okv_match_t              match;
	okv_upd_t                upd;
	okv_chain_t              chain [CAPACITY+1];
	logic [CAPACITY-1:0]     hit_vec;
	okv_chain_t              found;
	logic                    table_full;
	logic                    apply_go;
	logic                    take_req;

	okv_status_t             nx_status;
	logic [KEY_BITS-1:0]     nx_key;
	logic [VALUE_BITS-1:0]   nx_value;
	logic [COUNT_BITS-1:0]   nx_count;
	okv_act_t                nx_act;

	// the update cycle fires once the output register is free
	assign apply_go = (state_q == S_APPLY) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE) || apply_go;
	assign take_req = req.valid && req.ready;

	// match broadcast; pops look for the front rank or the back rank
	always_comb begin
		match.en      = (state_q == S_MATCH);
		match.by_rank = (cmd_q == CMD_POP_FIRST) || (cmd_q == CMD_POP_LAST);
		match.key     = key_q;
		match.rank    = (cmd_q == CMD_POP_FIRST) ? '0 : RANK_BITS'(count_q - 1'b1);
	end

	// cell row
	assign chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		okv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.match     (match),
			.upd       (upd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.hit       (hit_vec[i])
		);
	end

	assign found      = chain[CAPACITY];
	assign table_full = !found.free_seen;

	// result and update decision for the command in hand
	always_comb begin
		nx_status = ST_OK;
		nx_key    = '0;
		nx_value  = '0;
		nx_count  = count_q;
		nx_act    = ACT_NONE;
		unique case (cmd_q)
			CMD_LOOKUP: begin
				nx_key = key_q;
				if (found.hit) nx_value = found.value;
				else nx_status = ST_MISSING;
			end
			CMD_INS_FRONT, CMD_INS_BACK: begin
				nx_key = key_q;
				if (found.hit) begin
					nx_status = ST_EXISTS;
					nx_value  = found.value;
				end else if (table_full) begin
					nx_status = ST_FULL;
					nx_value  = value_q;
				end else begin
					nx_value = value_q;
					nx_count = COUNT_BITS'(count_q + 1'b1);
					nx_act   = (cmd_q == CMD_INS_FRONT) ? ACT_INS_FRONT : ACT_INS_BACK;
				end
			end
			CMD_REMOVE, CMD_MOVE_BACK: begin
				nx_key = key_q;
				if (!found.hit) begin
					nx_status = ST_MISSING;
				end else begin
					nx_value = found.value;
					if (cmd_q == CMD_REMOVE) begin
						nx_act   = ACT_DROP;
						nx_count = COUNT_BITS'(count_q - 1'b1);
					end else begin
						nx_act = ACT_MOVE;
					end
				end
			end
			CMD_POP_FIRST, CMD_POP_LAST: begin
				if (count_q == '0 || !found.hit) begin
					nx_status = ST_EMPTY;
				end else begin
					nx_key   = found.key;
					nx_value = found.value;
					nx_act   = ACT_DROP;
					nx_count = COUNT_BITS'(count_q - 1'b1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		upd.en    = apply_go;
		upd.act   = nx_act;
		upd.rank  = found.rank;
		upd.count = count_q;
		upd.key   = key_q;
		upd.value = value_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take_req) state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) state_q <= take_req ? S_MATCH : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (apply_go) count_q <= nx_count;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (take_req) begin
			cmd_q   <= req.cmd;
			key_q   <= req.req_key;
			value_q <= req.req_value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			status_q    <= nx_status;
			res_key_q   <= nx_key;
			res_value_q <= nx_value;
			res_count_q <= nx_count;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.res_key     = res_key_q;
	assign rsp.res_value   = res_value_q;
	assign rsp.entry_count = res_count_q;

	// checks
	`OKV_ASSERT_SAME(a_count_range, 1'b1, count_q <= COUNT_BITS'(CAPACITY))
	`OKV_ASSERT_SAME(a_single_hit, state_q == S_APPLY, $onehot0(hit_vec))
	`OKV_ASSERT_NEXT(a_take_to_match, take_req, state_q == S_MATCH)
	`OKV_ASSERT_SAME(a_result_from_apply, $rose(out_valid_q), $past(state_q == S_APPLY))

endmodule
